// ===== sv/rhc_pkg.sv =====
`default_nettype none
package rhc_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
   localparam int HQ_BITS       = 6 + HUE_FRAC_BITS;
   localparam int DIV_STAGES    = (CHANNEL_BITS > HQ_BITS) ? CHANNEL_BITS : HQ_BITS;
   localparam int NUM_BITS      = CHANNEL_BITS + DIV_STAGES;

   localparam logic [HUE_BITS-1:0] DEG60  = HUE_BITS'(60 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] DEG120 = HUE_BITS'(120 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] DEG240 = HUE_BITS'(240 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] DEG360 = HUE_BITS'(360 << HUE_FRAC_BITS);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] value;
      logic                    hue_undefined;
   } rsp_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue_base;
      logic                    neg;
      logic                    undef;
      logic [CHANNEL_BITS-1:0] value;
   } side_type;

   typedef struct packed {
      logic [NUM_BITS-1:0]     num_sat;
      logic [CHANNEL_BITS-1:0] den_sat;
      logic [NUM_BITS-1:0]     num_hue;
      logic [CHANNEL_BITS-1:0] den_hue;
      side_type                side;
   } mid_type;

endpackage
`default_nettype wire

// ===== sv/rhc_fifo.sv =====
`default_nettype none
module rhc_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rhc_front.sv =====
`default_nettype none
module rhc_front (
   input  wire rhc_pkg::req_type item,
   output rhc_pkg::mid_type      work
);

   localparam int C = rhc_pkg::CHANNEL_BITS;

   logic [C-1:0]   mx, mn, delta, mag;
   logic [C:0]     diff, diff_neg;
   logic [2*C-1:0] sat_prod;
   logic [C+5:0]   m60;
   logic [rhc_pkg::HUE_BITS-1:0] base;

   always_comb begin
      mx = item.red;
      if (item.green > mx) mx = item.green;
      if (item.blue > mx) mx = item.blue;
      mn = item.red;
      if (item.green < mn) mn = item.green;
      if (item.blue < mn) mn = item.blue;
      delta = mx - mn;

      // sector by largest channel, red wins ties, then green
      if (item.red == mx) begin
         diff = {1'b0, item.green} - {1'b0, item.blue};
         base = '0;
      end else if (item.green == mx) begin
         diff = {1'b0, item.blue} - {1'b0, item.red};
         base = rhc_pkg::DEG120;
      end else begin
         diff = {1'b0, item.red} - {1'b0, item.green};
         base = rhc_pkg::DEG240;
      end
      diff_neg = -diff;
      mag      = diff[C] ? diff_neg[C-1:0] : diff[C-1:0];

      sat_prod = {delta, {C{1'b0}}} - {{C{1'b0}}, delta};
      m60      = (C+6)'(mag) * (C+6)'(60);

      work.num_sat       = rhc_pkg::NUM_BITS'(sat_prod);
      work.den_sat       = mx;
      work.num_hue       = rhc_pkg::NUM_BITS'(m60) << rhc_pkg::HUE_FRAC_BITS;
      work.den_hue       = delta;
      work.side.hue_base = base;
      work.side.neg      = diff[C];
      work.side.undef    = (mx == '0) || (delta == '0);
      work.side.value    = mx;
   end

endmodule
`default_nettype wire

// ===== sv/rhc_div.sv =====
`default_nettype none
module rhc_div (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic [rhc_pkg::NUM_BITS-1:0]        num,
   input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    den,
   output logic [rhc_pkg::DIV_STAGES-1:0]           quo,
   output logic                                     rem_nz
);

   localparam int C = rhc_pkg::CHANNEL_BITS;
   localparam int N = rhc_pkg::DIV_STAGES;

   logic [C-1:0] rem_ff [N];
   logic [N-1:0] sh_ff  [N];
   logic [C-1:0] den_ff [N-1];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [C-1:0] rem_prev, rem_in, den_prev;
      logic [N-1:0] sh_prev, sh_in;
      logic [C:0]   t;
      logic         ge;

      if (k == 0) begin : g_first
         assign rem_prev = num[C+N-1:N];
         assign sh_prev  = num[N-1:0];
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign sh_prev  = sh_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      always_comb begin
         t      = {rem_prev, sh_prev[N-1]};
         ge     = (t >= {1'b0, den_prev});
         rem_in = ge ? C'(t - {1'b0, den_prev}) : t[C-1:0];
         sh_in  = {sh_prev[N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            sh_ff[k]  <= sh_in;
         end
      end

      if (k < N-1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign quo    = sh_ff[N-1];
   assign rem_nz = |rem_ff[N-1];

endmodule
`default_nettype wire

// ===== sv/rhc_back.sv =====
`default_nettype none
module rhc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             mid_empty,
   input  wire rhc_pkg::mid_type mid_data,
   output logic                  mid_pop,
   input  wire logic             out_full,
   output logic                  out_push,
   output rhc_pkg::rsp_type      out_data
);

   localparam int N  = rhc_pkg::DIV_STAGES;
   localparam int HB = rhc_pkg::HUE_BITS;

   logic              advance;
   logic [N-1:0]      valid_ff;
   rhc_pkg::side_type side_ff [N];
   logic [N-1:0]      quo_sat, quo_hue;
   logic              nz_sat, nz_hue;
   logic signed [HB:0] qq, h;
   rhc_pkg::side_type last;

   assign advance = !out_full;
   assign mid_pop = advance && !mid_empty;

   rhc_div u_div_sat (
      .clock  (clock),
      .en     (advance),
      .num    (mid_data.num_sat),
      .den    (mid_data.den_sat),
      .quo    (quo_sat),
      .rem_nz (nz_sat)
   );

   rhc_div u_div_hue (
      .clock  (clock),
      .en     (advance),
      .num    (mid_data.num_hue),
      .den    (mid_data.den_hue),
      .quo    (quo_hue),
      .rem_nz (nz_hue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-2:0], !mid_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= mid_data.side;
         for (int k = 1; k < N; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign last     = side_ff[N-1];
   assign out_push = advance && valid_ff[N-1];

   always_comb begin
      // floor toward minus infinity for negative offsets
      qq = (HB+1)'(quo_hue) + (HB+1)'(last.neg && nz_hue);
      h  = $signed({1'b0, last.hue_base}) + (last.neg ? -qq : qq);
      if (h < 0) begin
         h = h + $signed({1'b0, rhc_pkg::DEG360});
      end else if (h >= $signed({1'b0, rhc_pkg::DEG360})) begin
         h = h - $signed({1'b0, rhc_pkg::DEG360});
      end
      out_data.hue           = last.undef ? '0 : h[HB-1:0];
      out_data.saturation    = last.undef ? '0 : rhc_pkg::CHANNEL_BITS'(quo_sat);
      out_data.value         = last.value;
      out_data.hue_undefined = last.undef;
   end

endmodule
`default_nettype wire

// ===== sv/rgb_to_hsv_converter_core.sv =====
`default_nettype none
// channel   direction  ports                 transfer when
// request   in         req_data, push, full  push && !full
// response  out        rsp_data, empty, pop  pop && !empty
//
// one pixel per cycle sustained while the response queue is not full; hue and
// saturation come from the restoring divider pipelines, one quotient bit per stage
// reset is synchronous and clears queue counts and stage valid bits
// a full response queue stalls the divider pipeline; the 2-entry queue in front
// of it keeps full low while the pipeline moves
module rgb_to_hsv_converter_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rhc_pkg::req_type req_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output rhc_pkg::rsp_type      rsp_data
);

   rhc_pkg::mid_type mid_in, mid_out;
   logic             mid_empty, mid_pop;
   rhc_pkg::rsp_type out_in;
   logic             out_push, out_full;

   rhc_front u_front (
      .item (req_data),
      .work (mid_in)
   );

   rhc_fifo #(.WIDTH($bits(rhc_pkg::mid_type))) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (mid_in),
      .full  (full),
      .pop   (mid_pop),
      .empty (mid_empty),
      .rdata (mid_out)
   );

   rhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_out),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_in)
   );

   rhc_fifo #(.WIDTH($bits(rhc_pkg::rsp_type))) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_in),
      .full  (out_full),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("response queue overrun");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.hue < rhc_pkg::DEG360) else $error("hue out of range");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.hue_undefined) |-> (rsp_data.hue == '0 && rsp_data.saturation == '0))
      else $error("undefined hue not zeroed");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (mid_pop && !$past(reset)) |-> !mid_empty) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== tb/sv/rgb_to_hsv_converter_core_test.sv =====
`timescale 1ns / 1ps
module rgb_to_hsv_converter_core_test;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             pop = 1'b0;
   logic             full;
   logic             empty;
   rhc_pkg::req_type req_data = '0;
   rhc_pkg::rsp_type rsp_data;

   rhc_pkg::rsp_type pending_hsv[$];
   int      error_count = 0;
   bit      quiet_tail = 1'b0;

   typedef struct {
      rhc_pkg::req_type pixel;
      bit               fixed;
      rhc_pkg::rsp_type hsv;
   } pixel_row_type;

   pixel_row_type pixel_rows[$];

   rgb_to_hsv_converter_core dut (
      .clock(clock), .reset(reset), .push(push), .req_data(req_data), .full(full),
      .pop(pop), .empty(empty), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int floor_quot(int num, int den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   function automatic rhc_pkg::rsp_type hsv_of(rhc_pkg::req_type px);
      int r, g, b, mx, mn, delta, h, deg60, sat;
      rhc_pkg::rsp_type o;
      r = px.red; g = px.green; b = px.blue;
      deg60 = 60 * (1 << rhc_pkg::HUE_FRAC_BITS);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      o = '0;
      o.value = mx[rhc_pkg::CHANNEL_BITS-1:0];
      if (mx == 0 || delta == 0) begin
         o.hue_undefined = 1'b1;
      end else begin
         sat = (((1 << rhc_pkg::CHANNEL_BITS) - 1) * delta) / mx;
         o.saturation = sat[rhc_pkg::CHANNEL_BITS-1:0];
         if (r == mx) h = floor_quot(deg60 * (g - b), delta);
         else if (g == mx) h = 2 * deg60 + floor_quot(deg60 * (b - r), delta);
         else h = 4 * deg60 + floor_quot(deg60 * (r - g), delta);
         if (h < 0) h += 6 * deg60;
         if (h >= 6 * deg60) h -= 6 * deg60;
         o.hue = h[rhc_pkg::HUE_BITS-1:0];
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic send_pixel(rhc_pkg::req_type px, bit fixed, rhc_pkg::rsp_type hsv);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         gap = $urandom_range(1, 14);
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_hsv.push_back(fixed ? hsv : hsv_of(px));
      @(negedge clock);
   endtask

   function automatic void add_row(int r, int g, int b, bit fixed = 0,
                                   int h = 0, int s = 0, int v = 0, bit u = 0);
      pixel_row_type row;
      row.pixel = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
      row.fixed = fixed;
      row.hsv = '{hue: rhc_pkg::HUE_BITS'(h), saturation: 8'(s), value: 8'(v),
                  hue_undefined: u};
      pixel_rows.push_back(row);
   endfunction

   // response side
   initial begin
      int stall;
      @(negedge clock);
      while (1) begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            stall = $urandom_range(1, 14);
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (pending_hsv.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               rhc_pkg::rsp_type want;
               want = pending_hsv.pop_front();
               if (rsp_data.hue !== want.hue)
                  report_mismatch("hue", rsp_data.hue, want.hue);
               if (rsp_data.saturation !== want.saturation)
                  report_mismatch("saturation", rsp_data.saturation, want.saturation);
               if (rsp_data.value !== want.value)
                  report_mismatch("value", rsp_data.value, want.value);
               if (rsp_data.hue_undefined !== want.hue_undefined)
                  report_mismatch("hue_undefined", rsp_data.hue_undefined,
                                  want.hue_undefined);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      rhc_pkg::req_type px;
      int      k;
      add_row(0, 0, 0, 1, 0, 0, 0, 1);
      add_row(255, 255, 255, 1, 0, 0, 255, 1);
      add_row(77, 77, 77, 1, 0, 0, 77, 1);
      add_row(1, 1, 1, 1, 0, 0, 1, 1);
      add_row(255, 0, 0, 1, 0, 255, 255, 0);
      add_row(0, 255, 0, 1, 7680, 255, 255, 0);
      add_row(0, 0, 255, 1, 15360, 255, 255, 0);
      add_row(255, 255, 0, 1, 3840, 255, 255, 0);
      add_row(255, 0, 255);
      add_row(0, 255, 255);
      add_row(255, 0, 1);
      add_row(255, 1, 0);
      add_row(1, 0, 0);
      add_row(0, 1, 1);
      add_row(200, 200, 10);
      add_row(10, 200, 200);
      add_row(200, 10, 200);
      add_row(254, 255, 253);
      add_row(170, 85, 0);
      add_row(1, 2, 3);
      add_row(128, 127, 129);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (pixel_rows[i])
         send_pixel(pixel_rows[i].pixel, pixel_rows[i].fixed, pixel_rows[i].hsv);
      push <= 1'b0;
      while (pending_hsv.size() != 0) @(negedge clock);
      for (k = 0; k < 550; k++) begin
         if (k == 450) quiet_tail = 1'b1;
         case ($urandom_range(0, 5))
            0: begin
               px.red = 8'($urandom_range(0, 255));
               px.green = px.red;
               px.blue = ($urandom_range(0, 1) != 0) ? px.red : 8'($urandom_range(0, 255));
            end
            1: begin
               px.red = 8'($urandom_range(250, 255));
               px.green = 8'($urandom_range(0, 255));
               px.blue = 8'($urandom_range(0, 255));
            end
            2: begin
               px.red = 8'($urandom_range(0, 3));
               px.green = 8'($urandom_range(0, 3));
               px.blue = 8'($urandom_range(0, 3));
            end
            default: px = rhc_pkg::req_type'(24'($urandom));
         endcase
         send_pixel(px, 1'b0, '0);
      end
      push <= 1'b0;
      while (pending_hsv.size() != 0) @(negedge clock);
      repeat (rhc_pkg::DIV_STAGES + 6) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
